// ----- sv/sobet_pkg.sv -----
// Package for the Sobel edge threshold stream: widths, register indexes,
// luma weights and the types passed between the front end, queue and back end.
// No dependencies.
package sobet_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;

	// Configuration registers
	localparam int THR_W      = 12;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam logic [THR_W-1:0]   THRESHOLD_RST    = 12'd100;
	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

	// Squared magnitude and squared threshold
	localparam int MAG_W = 22;
	localparam logic [MAG_W-1:0] THR_SQ_RST = 22'd10000;

	// Luma weights, 16 fraction bits
	localparam int LUMA_ACC_W = 24;
	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;

	// Queue between front and back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Border position flags of one pixel
	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic last_col;
		logic last_row;
	} pos_flags_t;

	// One window snapshot: luma of all nine taps, alpha of the lower right four
	typedef struct packed {
		logic [2:0][2:0][7:0] lum;
		logic [1:0][1:0][7:0] alpha;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		pos_flags_t           flags;
	} win_entry_t;

endpackage

// ----- sv/sobet_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module sobet_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/sobet_front.sv -----
// Front end: accepts pixels, tracks position, computes luma, keeps the line
// stores and the 3x3 window, pushes window snapshots. Uses sobet_pkg, sobet_ram.
module sobet_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [31:0]                     in_data,
	input  logic                            frame_start,
	input  logic [sobet_pkg::IMG_W_W-1:0]   image_width,
	input  logic [sobet_pkg::IMG_H_W-1:0]   image_height,
	output logic                            push,
	output sobet_pkg::win_entry_t           push_data,
	input  logic                            q_full
);

	logic [sobet_pkg::COL_W-1:0]   col_q, c_cur, col_s1;
	logic [sobet_pkg::ROW_W-1:0]   row_q, r_cur, row_s1;
	logic [sobet_pkg::IMG_W_W-1:0] wm1;
	logic [sobet_pkg::IMG_H_W-1:0] hm1;
	logic                          last_col, last_row, accept, s1_adv;
	logic                          s1_valid_q, last_col_s1, last_row_s1, fwd_hit_s1;
	logic [7:0]                    red_s1, green_s1, blue_s1, alpha_s1, luma;
	logic [31:0]                   fwd_data_s1, ram_rdata, line_cur, line_wr;
	logic [sobet_pkg::LUMA_ACC_W-1:0] luma_sum;
	logic [15:0]                   pix;
	logic [2:0][2:0][15:0]         window_q, win_nxt;

	assign s1_adv   = s1_valid_q && !q_full;
	assign in_ready = !s1_valid_q || !q_full;
	assign accept   = in_valid && in_ready;

	// effective last column and last row
	always_comb begin
		if (image_width == '0) begin
			wm1 = '0;
		end else if (image_width > sobet_pkg::IMG_W_W'(sobet_pkg::MAX_WIDTH)) begin
			wm1 = sobet_pkg::IMG_W_W'(sobet_pkg::MAX_WIDTH - 1);
		end else begin
			wm1 = image_width - 1'b1;
		end
		hm1 = (image_height == '0) ? '0 : image_height - 1'b1;
	end

	assign c_cur    = frame_start ? '0 : col_q;
	assign r_cur    = frame_start ? '0 : row_q;
	assign last_col = sobet_pkg::IMG_W_W'(c_cur) >= wm1;
	assign last_row = r_cur >= hm1;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : r_cur + 1'b1;
			end else begin
				col_q <= c_cur + 1'b1;
				row_q <= r_cur;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// stage 1 payload; forward the line write of the leaving item on a same-column hit
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1      <= in_data[7:0];
			green_s1    <= in_data[15:8];
			blue_s1     <= in_data[23:16];
			alpha_s1    <= in_data[31:24];
			col_s1      <= c_cur;
			row_s1      <= r_cur;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			fwd_hit_s1  <= s1_adv && (col_s1 == c_cur);
			fwd_data_s1 <= line_wr;
		end
	end

	// luma, 16 fraction bits, truncated
	assign luma_sum = sobet_pkg::LUMA_ACC_W'(red_s1) * sobet_pkg::LUMA_ACC_W'(sobet_pkg::LUMA_R)
		+ sobet_pkg::LUMA_ACC_W'(green_s1) * sobet_pkg::LUMA_ACC_W'(sobet_pkg::LUMA_G)
		+ sobet_pkg::LUMA_ACC_W'(blue_s1) * sobet_pkg::LUMA_ACC_W'(sobet_pkg::LUMA_B);
	assign luma     = luma_sum[sobet_pkg::LUMA_ACC_W-1 -: 8];
	assign pix      = {luma, alpha_s1};

	// line stores: upper in the high half, middle in the low half
	assign line_cur = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign line_wr  = {line_cur[15:0], pix};

	sobet_ram #(
		.WIDTH(32),
		.DEPTH(sobet_pkg::MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (line_wr),
		.re    (accept),
		.raddr (c_cur),
		.rdata (ram_rdata)
	);

	// window shift, new column on the right
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nxt[i][0] = window_q[i][1];
			win_nxt[i][1] = window_q[i][2];
		end
		win_nxt[0][2] = line_cur[31:16];
		win_nxt[1][2] = line_cur[15:0];
		win_nxt[2][2] = pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q <= win_nxt;
		end
	end

	// snapshot for the back end
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				push_data.lum[i][j] = win_nxt[i][j][15:8];
			end
		end
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				push_data.alpha[i][j] = win_nxt[i+1][j+1][7:0];
			end
		end
		push_data.row            = row_s1;
		push_data.col            = col_s1;
		push_data.flags.r_ge1    = row_s1 != '0;
		push_data.flags.r_ge2    = row_s1 >= sobet_pkg::ROW_W'(2);
		push_data.flags.c_ge1    = col_s1 != '0;
		push_data.flags.c_ge2    = col_s1 >= sobet_pkg::COL_W'(2);
		push_data.flags.last_col = last_col_s1;
		push_data.flags.last_row = last_row_s1;
	end

	assign push = s1_adv;

endmodule

// ----- sv/sobet_fifo.sv -----
// Short queue of window snapshots between front and back end.
// Uses sobet_pkg.
module sobet_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sobet_pkg::win_entry_t push_data,
	output logic                  full,
	input  logic                  pop,
	output sobet_pkg::win_entry_t head,
	output logic                  empty
);

	sobet_pkg::win_entry_t         entry_q [sobet_pkg::QUEUE_DEPTH];
	logic [sobet_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [sobet_pkg::QPTR_W:0]    count_q;

	assign full  = count_q == (sobet_pkg::QPTR_W+1)'(sobet_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
`endif

endmodule

// ----- sv/sobet_back.sv -----
// Back end: walks the results of each window snapshot, computes the Sobel
// gradients and the threshold test, holds the output register. Uses sobet_pkg.
module sobet_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sobet_pkg::win_entry_t         head,
	input  logic                          empty,
	output logic                          pop,
	input  logic                          thr_neg,
	input  logic [sobet_pkg::MAG_W-1:0]   thr_sq,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    edge_res,
	output logic [7:0]                    alpha_out,
	output logic [sobet_pkg::COL_W-1:0]   out_col,
	output logic [sobet_pkg::ROW_W-1:0]   out_row,
	output logic                          last_of_run
);

	logic [3:0]                 mask, used_q, pending, pick, rest;
	logic                       bottom, right, b0_go, emit, b1_ready, b2_ready;
	logic [2:0][1:0]            rsel, csel;
	logic [2:0][2:0][7:0]       lsel;
	logic [9:0]                 sum_r, sum_l, sum_b, sum_t;
	logic signed [10:0]         gx, gy, gx_s1, gy_s1;
	logic [7:0]                 alpha_s1;
	logic [sobet_pkg::COL_W-1:0] col_s1;
	logic [sobet_pkg::ROW_W-1:0] row_s1;
	logic                       valid_s1, last_s1, out_valid_q;
	logic signed [21:0]         gx2, gy2;
	logic [sobet_pkg::MAG_W-1:0] mag;

	// result order: top left, top right, bottom left, bottom right
	assign mask[0] = head.flags.r_ge1 && head.flags.c_ge1;
	assign mask[1] = head.flags.r_ge1 && head.flags.last_col;
	assign mask[2] = head.flags.last_row && head.flags.c_ge1;
	assign mask[3] = head.flags.last_row && head.flags.last_col;
	assign pending = mask & ~used_q;
	assign pick    = pending & (~pending + 4'd1);
	assign rest    = pending & ~pick;
	assign bottom  = pick[2] || pick[3];
	assign right   = pick[1] || pick[3];

	assign b2_ready = !out_valid_q || out_ready;
	assign b1_ready = !valid_s1 || b2_ready;
	assign b0_go    = !empty && b1_ready;
	assign emit     = b0_go && (pending != '0);
	assign pop      = b0_go && (rest == '0);

	// results already sent for the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (b0_go) begin
			used_q <= (rest == '0) ? '0 : (used_q | pick);
		end
	end

	// border mapping of window rows and columns (repeated edge)
	always_comb begin
		if (!bottom) begin
			rsel = head.flags.r_ge2 ? {2'd2, 2'd1, 2'd0} : {2'd2, 2'd1, 2'd1};
		end else begin
			rsel = head.flags.r_ge1 ? {2'd2, 2'd2, 2'd1} : {2'd2, 2'd2, 2'd2};
		end
		if (!right) begin
			csel = head.flags.c_ge2 ? {2'd2, 2'd1, 2'd0} : {2'd2, 2'd1, 2'd1};
		end else begin
			csel = head.flags.c_ge1 ? {2'd2, 2'd2, 2'd1} : {2'd2, 2'd2, 2'd2};
		end
		for (int d = 0; d < 3; d++) begin
			for (int e = 0; e < 3; e++) begin
				lsel[d][e] = head.lum[rsel[d]][csel[e]];
			end
		end
	end

	// Sobel sums
	assign sum_r = 10'(lsel[0][2]) + {1'b0, lsel[1][2], 1'b0} + 10'(lsel[2][2]);
	assign sum_l = 10'(lsel[0][0]) + {1'b0, lsel[1][0], 1'b0} + 10'(lsel[2][0]);
	assign sum_b = 10'(lsel[2][0]) + {1'b0, lsel[2][1], 1'b0} + 10'(lsel[2][2]);
	assign sum_t = 10'(lsel[0][0]) + {1'b0, lsel[0][1], 1'b0} + 10'(lsel[0][2]);
	assign gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
	assign gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

	// gradient stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (b1_ready) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (b1_ready && emit) begin
			gx_s1    <= gx;
			gy_s1    <= gy;
			alpha_s1 <= head.alpha[bottom][right];
			col_s1   <= right ? head.col : head.col - 1'b1;
			row_s1   <= bottom ? head.row : head.row - 1'b1;
			last_s1  <= rest == '0;
		end
	end

	// magnitude and threshold
	assign gx2 = gx_s1 * gx_s1;
	assign gy2 = gy_s1 * gy_s1;
	assign mag = sobet_pkg::MAG_W'(gx2) + sobet_pkg::MAG_W'(gy2);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (b2_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (b2_ready && valid_s1) begin
			edge_res    <= (thr_neg || (mag > thr_sq)) ? 8'hFF : 8'h00;
			alpha_out   <= alpha_s1;
			out_col     <= col_s1;
			out_row     <= row_s1;
			last_of_run <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0(pick))
		else $error("more than one result picked");
`endif

endmodule

// ----- sv/sobel_edge_threshold_stream.sv -----
// Top level of the Sobel edge threshold stream: configuration registers and
// the front end, queue and back end. Uses sobet_pkg, sobet_front, sobet_fifo, sobet_back.
//
//   channel   dir  fields (tdata low bit up / tuser / tlast)
//   s_axis    in   red, green, blue, alpha / frame_start / -
//   m_axis    out  edge_res, alpha_out, out_col, out_row / - / last_of_run
//   cfg       in   cfg_wr_en, cfg_index, cfg_data (threshold, image_width, image_height)
//
// One pixel is taken per cycle unless the queue is full; a result passes stage 1, the queue,
// the gradient stage and the output register. A pixel in the last column or row releases two
// results, the last of a frame four; the back end sends one result per cycle unless stalled,
// so once the four-entry queue fills over the last row the input is taken at about half rate.
// Reset clears counters, window and queue; the line stores need no clearing pass.
// Either side may stall at any time; the output register holds its result until taken.
module sobel_edge_threshold_stream (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,   // red, green, blue, alpha
	input  logic [0:0]                        s_axis_tuser,   // frame_start
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [47:0]                       m_axis_tdata,   // edge_res, alpha_out, out_col, out_row
	output logic                              m_axis_tlast,
	input  logic                              cfg_wr_en,
	input  logic [sobet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sobet_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic signed [sobet_pkg::THR_W-1:0]   thr_q, thr_wr;
	logic signed [2*sobet_pkg::THR_W-1:0] thr_prod;
	logic [sobet_pkg::MAG_W-1:0]          thr_sq_q;
	logic [sobet_pkg::IMG_W_W-1:0]        width_q;
	logic [sobet_pkg::IMG_H_W-1:0]        height_q;
	logic                                 push, q_full, q_empty, pop;
	sobet_pkg::win_entry_t                push_data, head;
	logic [7:0]                           edge_res, alpha_out;
	logic [sobet_pkg::COL_W-1:0]          out_col;
	logic [sobet_pkg::ROW_W-1:0]          out_row;

	assign thr_wr   = cfg_data[sobet_pkg::THR_W-1:0];
	assign thr_prod = thr_wr * thr_wr;

	// configuration registers; the threshold square is kept with the threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= sobet_pkg::THRESHOLD_RST;
			thr_sq_q <= sobet_pkg::THR_SQ_RST;
			width_q  <= sobet_pkg::IMAGE_WIDTH_RST;
			height_q <= sobet_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sobet_pkg::REG_THRESHOLD: begin
					thr_q    <= thr_wr;
					thr_sq_q <= thr_prod[sobet_pkg::MAG_W-1:0];
				end
				sobet_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[sobet_pkg::IMG_W_W-1:0];
				end
				sobet_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[sobet_pkg::IMG_H_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sobet_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_data      (s_axis_tdata),
		.frame_start  (s_axis_tuser[0]),
		.image_width  (width_q),
		.image_height (height_q),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	sobet_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	sobet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.thr_neg     (thr_q[sobet_pkg::THR_W-1]),
		.thr_sq      (thr_sq_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.edge_res    (edge_res),
		.alpha_out   (alpha_out),
		.out_col     (out_col),
		.out_row     (out_row),
		.last_of_run (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, out_row, out_col, alpha_out, edge_res};

endmodule
